// File: rtl/core/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants for the decimal text converter
// Holds the ASCII codes, the result character record and the constant
// functions that build the powers-of-ten tables used by the front and back.
// ----------------------------------------------------------------------------
package sid_pkg;

   // ASCII codes that the converter emits.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Number base and the width of the constant tables. Nine times the largest
   // power of ten that a 64-bit magnitude needs fits in 68 bits.
   localparam int RADIX     = 10;
   localparam int POW_BITS  = 68;
   localparam int MAX_POWER = 19;

   // One result character and its end-of-number flag.
   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } char_type;

   // Returns mult times ten to the power exp, in POW_BITS bits.
   function automatic logic [POW_BITS-1:0] pow10_mult(input int mult, input int exp);
      logic [POW_BITS-1:0] acc;
      acc = POW_BITS'(mult);
      for (int i = 0; i < exp; i++) begin
         acc = acc * POW_BITS'(RADIX);
      end
      return acc;
   endfunction

   // Number of decimal digits of the largest magnitude of a signed value of
   // the given width, which is two to the power (bits - 1).
   function automatic int num_digits(input int bits);
      logic [POW_BITS-1:0] limit;
      int                  n;
      limit = POW_BITS'(1) << (bits - 1);
      n     = 1;
      for (int k = 1; k <= MAX_POWER; k++) begin
         if (pow10_mult(1, k) <= limit) begin
            n = k + 1;
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/core/sid_front.sv
// ----------------------------------------------------------------------------
// sid_front: input stage of the decimal text converter
// Accepts one signed value per transaction, forms its sign and unsigned
// magnitude, then counts its decimal digits and hands the job to the queue.
// ----------------------------------------------------------------------------
module sid_front #(
   parameter int VALUE_BITS = 32,
   parameter int NUM_DIGITS = 10,
   parameter int IDX_BITS   = 4,
   parameter int JOB_BITS   = 37
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         job_push,
   output logic [JOB_BITS-1:0]          job_data,
   input  logic                         job_full
);

   localparam int CMP_BITS = VALUE_BITS + 4;

   logic                  stage_valid_ff, stage_valid_in;
   logic                  stage_neg_ff, stage_neg_in;
   logic [VALUE_BITS-1:0] stage_mag_ff, stage_mag_in;
   logic                  accept;
   logic [IDX_BITS-1:0]   top_idx;
   logic [CMP_BITS-1:0]   mag_wide;

   // The stage holds one value until the queue takes it.
   assign req_full = stage_valid_ff && job_full;
   assign accept   = req_push && !req_full;
   assign job_push = stage_valid_ff && !job_full;

   // Sign and magnitude; the most negative value negates to its own unsigned
   // magnitude, which is what we want.
   always_comb begin
      stage_neg_in = req_value[VALUE_BITS-1];
      if (req_value[VALUE_BITS-1]) begin
         stage_mag_in = VALUE_BITS'(0) - VALUE_BITS'(req_value);
      end else begin
         stage_mag_in = VALUE_BITS'(req_value);
      end
   end

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (job_push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_neg_ff <= stage_neg_in;
         stage_mag_ff <= stage_mag_in;
      end
   end

   // Position of the leading digit: the highest power of ten that does not
   // exceed the magnitude. The compares are independent and monotonic.
   assign mag_wide = CMP_BITS'(stage_mag_ff);

   always_comb begin
      top_idx = '0;
      for (int k = 1; k < NUM_DIGITS; k++) begin
         if (mag_wide >= CMP_BITS'(sid_pkg::pow10_mult(1, k))) begin
            top_idx = IDX_BITS'(k);
         end
      end
   end

   assign job_data = {stage_neg_ff, top_idx, stage_mag_ff};

endmodule

// File: rtl/core/sid_queue.sv
// ----------------------------------------------------------------------------
// sid_queue: two-entry job queue
// Decouples the classifying front from the digit generator so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module sid_queue #(
   parameter int WIDTH = 37
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/sid_back.sv
// ----------------------------------------------------------------------------
// sid_back: digit generator of the decimal text converter
// Takes one job at a time, emits the minus sign if needed, then one digit per
// cycle unless the output stalls, from the leading position down, comparing
// the remaining magnitude with the nine multiples of the current power of ten.
// ----------------------------------------------------------------------------
module sid_back #(
   parameter int VALUE_BITS = 32,
   parameter int NUM_DIGITS = 10,
   parameter int IDX_BITS   = 4,
   parameter int JOB_BITS   = 37
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [JOB_BITS-1:0]  job_data,
   input  logic                 job_empty,
   output logic                 job_pop,
   output sid_pkg::char_type    out_char,
   output logic                 out_valid,
   input  logic                 out_pop
);

   localparam int CMP_BITS = VALUE_BITS + 4;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIGIT = 2'd1;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   sid_pkg::char_type     out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  advance;
   logic                  job_neg;
   logic [IDX_BITS-1:0]   job_idx;
   logic [VALUE_BITS-1:0] job_mag;
   logic [CMP_BITS-1:0]   step_tbl [NUM_DIGITS][9];
   logic [CMP_BITS-1:0]   mag_wide;
   logic [CMP_BITS-1:0]   step_sub;
   logic [3:0]            digit;

   assign {job_neg, job_idx, job_mag} = job_data;

   // Multiples one to nine of each power of ten, a constant table.
   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_pow
      for (genvar j = 0; j < 9; j++) begin : g_mult
         assign step_tbl[k][j] = CMP_BITS'(sid_pkg::pow10_mult(j + 1, k));
      end
   end

   // The output register moves on when it is empty or being read.
   assign advance   = !out_valid_ff || out_pop;
   assign out_char  = out_ff;
   assign out_valid = out_valid_ff;
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty && advance;

   // Digit at the current position: the largest multiple that fits.
   assign mag_wide = CMP_BITS'(mag_ff);

   always_comb begin
      digit    = 4'd0;
      step_sub = '0;
      for (int j = 0; j < 9; j++) begin
         if (mag_wide >= step_tbl[idx_ff][j]) begin
            digit    = 4'(j + 1);
            step_sub = step_tbl[idx_ff][j];
         end
      end
   end

   // Sequencer: load a job, then walk down the digit positions.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = advance ? 1'b0 : out_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               mag_in   = job_mag;
               idx_in   = job_idx;
               state_in = ST_DIGIT;
               if (job_neg) begin
                  out_in.text  = sid_pkg::CHAR_MINUS;
                  out_in.last  = 1'b0;
                  out_valid_in = 1'b1;
               end
            end
         end
         ST_DIGIT: begin
            if (advance) begin
               out_in.text  = sid_pkg::CHAR_ZERO + 8'(digit);
               out_in.last  = (idx_ff == '0);
               out_valid_in = 1'b1;
               mag_in       = VALUE_BITS'(mag_wide - step_sub);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   // The final digit of a number sends the sequencer back to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && advance && idx_ff == '0) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last digit");

   // A digit step always yields a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && advance) |=>
         (out_valid_ff && out_ff.text >= sid_pkg::CHAR_ZERO &&
          out_ff.text <= sid_pkg::CHAR_ZERO + 8'd9))
      else $error("digit step produced a character outside 0 to 9");

   // A minus sign never ends a number.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.text == sid_pkg::CHAR_MINUS) |-> !out_ff.last)
      else $error("minus sign flagged as last character");

   // The leading digit of a multi-digit number is never zero.
   a_leading_nonzero: assert property (@(posedge clock) disable iff (reset)
      (job_pop && job_idx != '0) |=> (digit != 4'd0))
      else $error("leading digit is zero");

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts each signed value to its decimal characters, most significant
// first, with a leading minus for negative values and a flag on the last one.
//
//   Channel   Ports                               Direction
//   request   req_push, req_full, req_value       in
//   response  rsp_pop, rsp_empty, rsp_text_char,  out
//             rsp_last_char
//
// The digit generator takes one number at a time. On the load of a job the
// minus sign, if any, enters the output register; the generator then emits
// one digit per cycle unless the response stalls, leading position first.
// Each value passes the front stage register and the job queue on its way.
// Reset clears all control state. A stalled response holds the generator,
// while the front stage and a two-entry job queue keep taking requests.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [7:0]                   rsp_text_char,
   output logic                         rsp_last_char
);

   localparam int NUM_DIGITS = sid_pkg::num_digits(VALUE_BITS);
   localparam int IDX_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int JOB_BITS   = 1 + IDX_BITS + VALUE_BITS;

   logic                job_push;
   logic [JOB_BITS-1:0] job_in_data;
   logic                job_full;
   logic                job_pop;
   logic [JOB_BITS-1:0] job_out_data;
   logic                job_empty;
   sid_pkg::char_type   out_char;
   logic                out_valid;

   // Front stage: sign, magnitude and digit count.
   sid_front #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_BITS   (IDX_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .job_push  (job_push),
      .job_data  (job_in_data),
      .job_full  (job_full)
   );

   // Job queue between front and back.
   sid_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   // Digit generator with its output register.
   sid_back #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_BITS   (IDX_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_out_data),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .out_char  (out_char),
      .out_valid (out_valid),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty     = !out_valid;
   assign rsp_text_char = out_char.text;
   assign rsp_last_char = out_char.last;

endmodule
